// ----- rtl/bhs_pkg.sv -----
// Shared types and codes for the Brent hash set engine.
package bhs_pkg;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_CLEAR  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		STS_DONE      = 3'd0,
		STS_PRESENT   = 3'd1,
		STS_NOT_FOUND = 3'd2,
		STS_FULL      = 3'd3,
		STS_READ_ONLY = 3'd4
	} status_t;

	localparam logic [2:0] REG_READ_ONLY = 3'd0;

	typedef enum logic [2:0] {
		RD_CUR,
		RD_MP,
		RD_FPM1,
		RD_OTHER,
		RD_WHERE,
		RD_LN
	} rd_sel_t;

	typedef enum logic [3:0] {
		WR_NONE,
		WR_CLR,
		WR_PUT_MP,
		WR_MOVE_FR,
		WR_MOVE_FIN,
		WR_FIX_OTHER,
		WR_CHAIN_FR,
		WR_CHAIN_MP,
		WR_UNLINK_PREV,
		WR_FREE_WHERE,
		WR_PULL,
		WR_FREE_SUCC
	} wr_op_t;

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_CLR,
		S_HK_GO,
		S_HK_WAIT,
		S_LOC_RD,
		S_LOC_CHK,
		S_DECIDE,
		S_INS_RD,
		S_INS_CHK,
		S_SCAN,
		S_SCAN_CHK,
		S_HO_GO,
		S_HO_WAIT,
		S_WALK_RD,
		S_WALK_CHK,
		S_MOVE_FR,
		S_MOVE_MP,
		S_CHAIN_FR,
		S_CHAIN_MP,
		S_DEL_RD,
		S_DEL_CHK,
		S_DEL_FREE,
		S_DEL_SCHK,
		S_DEL_SUCC,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic    ld_req;
		rd_sel_t rd_sel;
		wr_op_t  wr_op;
		logic    hash_start;
		logic    hash_src_mp;
		logic    ld_mp;
		logic    loc_init;
		logic    loc_adv;
		logic    loc_hit;
		logic    mp_save;
		logic    scan_restart;
		logic    scan_dec;
		logic    ld_fr;
		logic    ld_other_hash;
		logic    ld_other_link;
		logic    steps_clr;
		logic    steps_inc;
		logic    ln_save;
		logic    fin_clear;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    set_status;
		status_t status_val;
		logic    out_load;
	} bhs_cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    hash_done;
		logic    hres_eq_mp;
		logic    cur_end;
		logic    hit;
		logic    rd_used;
		logic    ln_is_mp;
		logic    ln_nil;
		logic    steps_max;
		logic    fp_zero;
		logic    restarted;
		logic    prev_nil;
		logic    clr_last;
		logic    found;
		logic    out_free;
	} bhs_sts_t;

endpackage

// ----- rtl/brent_hash_set_engine.sv -----
// Top level of the Brent hash set engine: stream ports, register port, controller and datapath.
// Each request hashes the key in a pipelined hash unit and then walks the key's collision chain,
// reading and then checking one slot at a time. An insert that collides adds a downward free-slot
// scan, a second hash of the occupant's key and, unless that key is in its main position, a walk
// of its chain; a delete adds an unlink, a free or a pull of its successor. A clear request, unless
// read-only is set, sweeps all SLOTS slots, one per cycle. After reset the same clearing pass runs
// before the first request is taken; register writes are accepted throughout.
module brent_hash_set_engine import bhs_pkg::*; #(
	parameter int SLOTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // [1:0] opcode, [65:2] key, [71:66] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] found, [3:1] status, [12:4] element_count, [15:13] zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic     read_only_q;
	bhs_cmd_t cmd;
	bhs_sts_t sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_only_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == REG_READ_ONLY) begin
			read_only_q <= pwdata[0];
		end
	end

	assign prdata = (paddr == REG_READ_ONLY) ? {31'd0, read_only_q} : 32'd0;

	bhs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.in_op     (opcode_t'(s_tdata[1:0])),
		.read_only (read_only_q),
		.sts       (sts),
		.s_tready  (s_tready),
		.cmd       (cmd)
	);

	bhs_dp #(.SLOTS(SLOTS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);
endmodule

// ----- rtl/bhs_hash.sv -----
// Main-position hash: sum of key halves reduced modulo (SLOTS-1)|1 by reciprocal multiplication.
module bhs_hash import bhs_pkg::*; #(
	parameter int SLOTS = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [63:0]                value,
	output logic                       done,
	output logic [$clog2(SLOTS)-1:0]   result
);
	localparam int AW  = $clog2(SLOTS);
	localparam int RW  = AW + 1;
	localparam int MOD = (SLOTS - 1) | 1;
	localparam int LG  = $clog2(MOD);
	localparam int SH  = 32 + LG;
	// The reciprocal is scaled so that the quotient estimate is at most one too low.
	localparam logic [63:0]   RECIP   = (64'd1 << SH) / 64'(MOD);
	localparam logic [32:0]   RECIP_W = RECIP[32:0];
	localparam logic [16:0]   MOD_W   = 17'(MOD);
	localparam logic [RW-1:0] MOD_R   = RW'(MOD);

	logic [3:0]    vld_q;
	logic          done_q;
	logic [31:0]   sum_q;
	logic [64:0]   prod_q;
	logic [31:0]   qm_q;
	logic [RW-1:0] rem_q;
	logic [AW-1:0] res_q;
	logic [64:0]   quo;
	logic [48:0]   qm_full;
	logic [31:0]   diff;
	logic [RW-1:0] fin;

	always_comb begin
		quo     = prod_q >> SH;
		qm_full = 49'(quo[31:0]) * 49'(MOD_W);
		diff    = sum_q - qm_q;
		fin     = (rem_q >= MOD_R) ? rem_q - MOD_R : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			done_q <= 1'b0;
		end else begin
			vld_q <= {vld_q[2:0], start};
			if (start) done_q <= 1'b0;
			else if (vld_q[3]) done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) sum_q <= value[31:0] + value[63:32];
		prod_q <= 65'(sum_q) * 65'(RECIP_W);
		qm_q   <= qm_full[31:0];
		rem_q  <= diff[RW-1:0];
		res_q  <= fin[AW-1:0];
	end

	assign done   = done_q;
	assign result = res_q;
endmodule

// ----- rtl/bhs_ctrl.sv -----
// Controller state machine sequencing lookup, insert, delete and clear.
module bhs_ctrl import bhs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	input  opcode_t  in_op,
	input  logic     read_only,
	input  bhs_sts_t sts,
	output logic     s_tready,
	output bhs_cmd_t cmd
);
	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_INIT: if (sts.clr_last) state_nxt = S_IDLE;
			S_IDLE: begin
				if (s_tvalid) begin
					if (in_op == OP_CLEAR) state_nxt = read_only ? S_RESULT : S_CLR;
					else state_nxt = S_HK_GO;
				end
			end
			S_CLR: if (sts.clr_last) state_nxt = S_RESULT;
			S_HK_GO: state_nxt = S_HK_WAIT;
			S_HK_WAIT: if (sts.hash_done) state_nxt = S_LOC_RD;
			S_LOC_RD: state_nxt = sts.cur_end ? S_DECIDE : S_LOC_CHK;
			S_LOC_CHK: state_nxt = sts.hit ? S_DECIDE : S_LOC_RD;
			S_DECIDE: begin
				case (sts.op)
					OP_INSERT: state_nxt = (read_only || sts.found) ? S_RESULT : S_INS_RD;
					OP_DELETE: state_nxt = (!read_only && sts.found) ? S_DEL_RD : S_RESULT;
					default:   state_nxt = S_RESULT;
				endcase
			end
			S_INS_RD: state_nxt = S_INS_CHK;
			S_INS_CHK: state_nxt = sts.rd_used ? S_SCAN : S_RESULT;
			S_SCAN: begin
				if (!sts.fp_zero) state_nxt = S_SCAN_CHK;
				else if (sts.restarted) state_nxt = S_RESULT;
			end
			S_SCAN_CHK: state_nxt = sts.rd_used ? S_SCAN : S_HO_GO;
			S_HO_GO: state_nxt = S_HO_WAIT;
			S_HO_WAIT: begin
				if (sts.hash_done) state_nxt = sts.hres_eq_mp ? S_CHAIN_FR : S_WALK_RD;
			end
			S_WALK_RD: state_nxt = S_WALK_CHK;
			S_WALK_CHK: begin
				if (sts.ln_is_mp || sts.ln_nil || sts.steps_max) state_nxt = S_MOVE_FR;
				else state_nxt = S_WALK_RD;
			end
			S_MOVE_FR:  state_nxt = S_MOVE_MP;
			S_MOVE_MP:  state_nxt = S_RESULT;
			S_CHAIN_FR: state_nxt = S_CHAIN_MP;
			S_CHAIN_MP: state_nxt = S_RESULT;
			S_DEL_RD:   state_nxt = S_DEL_CHK;
			S_DEL_CHK: begin
				if (!sts.prev_nil) state_nxt = S_DEL_FREE;
				else if (sts.ln_nil) state_nxt = S_RESULT;
				else state_nxt = S_DEL_SCHK;
			end
			S_DEL_FREE: state_nxt = S_RESULT;
			S_DEL_SCHK: state_nxt = S_DEL_SUCC;
			S_DEL_SUCC: state_nxt = S_RESULT;
			S_RESULT: if (sts.out_free) state_nxt = S_IDLE;
			default: state_nxt = S_INIT;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rd_sel = RD_CUR;
		cmd.wr_op = WR_NONE;
		cmd.status_val = STS_DONE;
		s_tready = 1'b0;
		case (state_q)
			S_INIT: begin
				cmd.wr_op = WR_CLR;
				cmd.steps_inc = 1'b1;
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.ld_req = 1'b1;
					if (in_op == OP_CLEAR && read_only) begin
						cmd.set_status = 1'b1;
						cmd.status_val = STS_READ_ONLY;
					end
				end
			end
			S_CLR: begin
				cmd.wr_op = WR_CLR;
				cmd.steps_inc = 1'b1;
				if (sts.clr_last) begin
					cmd.fin_clear = 1'b1;
					cmd.set_status = 1'b1;
					cmd.status_val = STS_DONE;
				end
			end
			S_HK_GO: cmd.hash_start = 1'b1;
			S_HK_WAIT: begin
				if (sts.hash_done) begin
					cmd.ld_mp = 1'b1;
					cmd.loc_init = 1'b1;
				end
			end
			S_LOC_RD: cmd.rd_sel = RD_CUR;
			S_LOC_CHK: begin
				if (sts.hit) cmd.loc_hit = 1'b1;
				else cmd.loc_adv = 1'b1;
			end
			S_DECIDE: begin
				cmd.set_status = 1'b1;
				if (sts.op == OP_LOOKUP) begin
					cmd.status_val = sts.found ? STS_DONE : STS_NOT_FOUND;
				end else if (read_only) begin
					cmd.status_val = STS_READ_ONLY;
				end else if (sts.op == OP_INSERT) begin
					cmd.status_val = sts.found ? STS_PRESENT : STS_DONE;
				end else begin
					cmd.status_val = sts.found ? STS_DONE : STS_NOT_FOUND;
				end
			end
			S_INS_RD: cmd.rd_sel = RD_MP;
			S_INS_CHK: begin
				if (sts.rd_used) begin
					cmd.mp_save = 1'b1;
				end else begin
					cmd.wr_op = WR_PUT_MP;
					cmd.cnt_inc = 1'b1;
				end
			end
			S_SCAN: begin
				if (!sts.fp_zero) begin
					cmd.scan_dec = 1'b1;
					cmd.rd_sel = RD_FPM1;
				end else if (sts.restarted) begin
					cmd.set_status = 1'b1;
					cmd.status_val = STS_FULL;
				end else begin
					cmd.scan_restart = 1'b1;
				end
			end
			S_SCAN_CHK: if (!sts.rd_used) cmd.ld_fr = 1'b1;
			S_HO_GO: begin
				cmd.hash_start = 1'b1;
				cmd.hash_src_mp = 1'b1;
			end
			S_HO_WAIT: begin
				if (sts.hash_done) begin
					cmd.ld_other_hash = 1'b1;
					cmd.steps_clr = 1'b1;
				end
			end
			S_WALK_RD: cmd.rd_sel = RD_OTHER;
			S_WALK_CHK: begin
				if (sts.ln_is_mp) begin
					cmd.wr_op = WR_FIX_OTHER;
				end else if (!sts.ln_nil && !sts.steps_max) begin
					cmd.ld_other_link = 1'b1;
					cmd.steps_inc = 1'b1;
				end
			end
			S_MOVE_FR: cmd.wr_op = WR_MOVE_FR;
			S_MOVE_MP: begin
				cmd.wr_op = WR_MOVE_FIN;
				cmd.cnt_inc = 1'b1;
			end
			S_CHAIN_FR: cmd.wr_op = WR_CHAIN_FR;
			S_CHAIN_MP: begin
				cmd.wr_op = WR_CHAIN_MP;
				cmd.cnt_inc = 1'b1;
			end
			S_DEL_RD: cmd.rd_sel = RD_WHERE;
			S_DEL_CHK: begin
				cmd.ln_save = 1'b1;
				if (!sts.prev_nil) begin
					cmd.wr_op = WR_UNLINK_PREV;
				end else if (sts.ln_nil) begin
					cmd.wr_op = WR_FREE_WHERE;
					cmd.cnt_dec = 1'b1;
				end else begin
					cmd.rd_sel = RD_LN;
				end
			end
			S_DEL_FREE: begin
				cmd.wr_op = WR_FREE_WHERE;
				cmd.cnt_dec = 1'b1;
			end
			S_DEL_SCHK: cmd.wr_op = WR_PULL;
			S_DEL_SUCC: begin
				cmd.wr_op = WR_FREE_SUCC;
				cmd.cnt_dec = 1'b1;
			end
			S_RESULT: cmd.out_load = sts.out_free;
			default: cmd.rd_sel = RD_CUR;
		endcase
	end
endmodule

// ----- rtl/bhs_dp.sv -----
// Datapath: slot memories, chain and free-slot registers, count and result register.
module bhs_dp import bhs_pkg::*; #(
	parameter int SLOTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [71:0] s_tdata,
	input  logic        m_tready,
	input  bhs_cmd_t    cmd,
	output bhs_sts_t    sts,
	output logic        m_tvalid,
	output logic [15:0] m_tdata
);
	localparam int AW = $clog2(SLOTS);
	localparam int LW = AW + 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [LW-1:0] NIL = LW'(SLOTS);

	logic [63:0]   key_mem  [SLOTS];
	logic [LW-1:0] next_mem [SLOTS];
	logic          used_mem [SLOTS];

	opcode_t       op_q;
	logic [63:0]   key_q;
	logic          found_q;
	logic          restarted_q;
	logic [AW-1:0] mp_q, fr_q, other_q, where_q;
	logic [LW-1:0] cur_q, prev_q, wprev_q, ln_q, steps_q, fp_q;
	logic [63:0]   mpkey_q;
	logic [LW-1:0] mpnext_q;
	logic [CW-1:0] count_q;
	status_t       status_q;

	logic [63:0]   rd_key_q;
	logic [LW-1:0] rd_next_q;
	logic          rd_used_q;
	logic [AW-1:0] rd_addr;
	logic [LW-1:0] ln;
	logic [LW-1:0] fp_m1;

	logic          hash_done;
	logic [AW-1:0] hash_res;

	logic          key_we, used_we, next_we, used_wd;
	logic [AW-1:0] key_wa, used_wa, next_wa;
	logic [63:0]   key_wd;
	logic [LW-1:0] next_wd;

	logic          out_valid_q, out_found_q;
	status_t       out_status_q;
	logic [8:0]    out_count_q;

	bhs_hash #(.SLOTS(SLOTS)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.hash_start),
		.value  (cmd.hash_src_mp ? mpkey_q : key_q),
		.done   (hash_done),
		.result (hash_res)
	);

	// Stored links are either a slot index or the null link.
	assign ln    = (rd_next_q < NIL) ? rd_next_q : NIL;
	assign fp_m1 = fp_q - LW'(1);

	always_comb begin
		case (cmd.rd_sel)
			RD_CUR:   rd_addr = cur_q[AW-1:0];
			RD_MP:    rd_addr = mp_q;
			RD_FPM1:  rd_addr = fp_m1[AW-1:0];
			RD_OTHER: rd_addr = other_q;
			RD_WHERE: rd_addr = where_q;
			RD_LN:    rd_addr = ln[AW-1:0];
			default:  rd_addr = cur_q[AW-1:0];
		endcase
	end

	always_comb begin
		key_we = 1'b0;  key_wa = mp_q;  key_wd = key_q;
		used_we = 1'b0; used_wa = mp_q; used_wd = 1'b1;
		next_we = 1'b0; next_wa = mp_q; next_wd = NIL;
		case (cmd.wr_op)
			WR_CLR: begin
				used_we = 1'b1; used_wa = steps_q[AW-1:0]; used_wd = 1'b0;
				next_we = 1'b1; next_wa = steps_q[AW-1:0];
			end
			WR_PUT_MP: begin
				key_we = 1'b1;
				used_we = 1'b1;
			end
			WR_MOVE_FR: begin
				key_we = 1'b1;  key_wa = fr_q;  key_wd = mpkey_q;
				used_we = 1'b1; used_wa = fr_q;
				next_we = 1'b1; next_wa = fr_q; next_wd = mpnext_q;
			end
			WR_MOVE_FIN: begin
				key_we = 1'b1;
				used_we = 1'b1;
				next_we = 1'b1;
			end
			WR_FIX_OTHER: begin
				next_we = 1'b1; next_wa = other_q; next_wd = {1'b0, fr_q};
			end
			WR_CHAIN_FR: begin
				key_we = 1'b1;  key_wa = fr_q;
				used_we = 1'b1; used_wa = fr_q;
				next_we = 1'b1; next_wa = fr_q; next_wd = mpnext_q;
			end
			WR_CHAIN_MP: begin
				next_we = 1'b1; next_wd = {1'b0, fr_q};
			end
			WR_UNLINK_PREV: begin
				next_we = 1'b1; next_wa = wprev_q[AW-1:0]; next_wd = ln;
			end
			WR_FREE_WHERE: begin
				used_we = 1'b1; used_wa = where_q; used_wd = 1'b0;
				next_we = 1'b1; next_wa = where_q;
			end
			WR_PULL: begin
				key_we = 1'b1;  key_wa = where_q; key_wd = rd_key_q;
				next_we = 1'b1; next_wa = where_q; next_wd = ln;
			end
			WR_FREE_SUCC: begin
				used_we = 1'b1; used_wa = ln_q[AW-1:0]; used_wd = 1'b0;
				next_we = 1'b1; next_wa = ln_q[AW-1:0];
			end
			default: key_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (key_we) key_mem[key_wa] <= key_wd;
		if (used_we) used_mem[used_wa] <= used_wd;
		if (next_we) next_mem[next_wa] <= next_wd;
		rd_key_q  <= key_mem[rd_addr];
		rd_used_q <= used_mem[rd_addr];
		rd_next_q <= next_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= OP_LOOKUP;
			found_q     <= 1'b0;
			restarted_q <= 1'b0;
			steps_q     <= '0;
			fp_q        <= NIL;
			count_q     <= '0;
			status_q    <= STS_DONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ld_req) begin
				op_q        <= opcode_t'(s_tdata[1:0]);
				found_q     <= 1'b0;
				restarted_q <= 1'b0;
				steps_q     <= '0;
			end
			if (cmd.loc_init || cmd.steps_clr) steps_q <= '0;
			if (cmd.loc_adv || cmd.steps_inc) steps_q <= steps_q + LW'(1);
			if (cmd.loc_hit) found_q <= 1'b1;
			if (cmd.scan_restart) begin
				fp_q        <= NIL;
				restarted_q <= 1'b1;
			end
			if (cmd.scan_dec) fp_q <= fp_m1;
			if (cmd.fin_clear) begin
				fp_q    <= NIL;
				count_q <= '0;
			end
			if (cmd.cnt_inc) count_q <= count_q + CW'(1);
			if (cmd.cnt_dec && count_q != '0) count_q <= count_q - CW'(1);
			if (cmd.set_status) status_q <= cmd.status_val;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_req) key_q <= s_tdata[65:2];
		if (cmd.ld_mp) mp_q <= hash_res;
		if (cmd.loc_init) begin
			cur_q  <= {1'b0, hash_res};
			prev_q <= NIL;
		end
		if (cmd.loc_adv) begin
			prev_q <= cur_q;
			cur_q  <= ln;
		end
		if (cmd.loc_hit) begin
			where_q <= cur_q[AW-1:0];
			wprev_q <= prev_q;
		end
		if (cmd.mp_save) begin
			mpkey_q  <= rd_key_q;
			mpnext_q <= ln;
		end
		if (cmd.ld_fr) fr_q <= fp_q[AW-1:0];
		if (cmd.ld_other_hash) other_q <= hash_res;
		if (cmd.ld_other_link) other_q <= ln[AW-1:0];
		if (cmd.ln_save) ln_q <= ln;
		if (cmd.out_load) begin
			out_found_q  <= found_q;
			out_status_q <= status_q;
			out_count_q  <= 9'(count_q);
		end
	end

	always_comb begin
		sts.op         = op_q;
		sts.hash_done  = hash_done;
		sts.hres_eq_mp = (hash_res == mp_q);
		sts.cur_end    = (steps_q == NIL) || (cur_q >= NIL);
		sts.hit        = rd_used_q && (rd_key_q == key_q);
		sts.rd_used    = rd_used_q;
		sts.ln_is_mp   = (ln == {1'b0, mp_q});
		sts.ln_nil     = (ln == NIL);
		sts.steps_max  = (steps_q == NIL);
		sts.fp_zero    = (fp_q == '0);
		sts.restarted  = restarted_q;
		sts.prev_nil   = (wprev_q == NIL);
		sts.clr_last   = (steps_q == NIL - LW'(1));
		sts.found      = found_q;
		sts.out_free   = !out_valid_q || m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_count_q, out_status_q, out_found_q};
endmodule
